@@ src/lkt_pkg.sv @@
`timescale 1ns / 1ps
// lkt_pkg: shared types and constants for the link key table.
// Used by lkt_cell and link_key_table; depends on nothing else.
package lkt_pkg;

    // Table geometry
    localparam int SLOTS  = 6;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // slot index width
    localparam int CNT_W  = $clog2(SLOTS + 1);                  // 0..SLOTS

    // Field widths fixed by the interface
    localparam int OP_W    = 3;
    localparam int ADDR_W  = 48;
    localparam int KEY_W   = 64;
    localparam int KIND_W  = 4;
    localparam int COUNT_W = 3;
    localparam int CTR_W   = 32;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP  = 3'd0,
        OP_STORE   = 3'd1,
        OP_DELETE  = 3'd2,
        OP_ITER    = 3'd3,
        OP_RESTART = 3'd4,
        OP_CLEAR   = 3'd5,
        OP_RESTORE = 3'd6
    } t_op;

    // Input item
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic [KEY_W-1:0]  key_high;
        logic [KEY_W-1:0]  key_low;
        logic [KIND_W-1:0] key_kind;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic               found;
        logic [ADDR_W-1:0]  out_address;
        logic [KEY_W-1:0]   out_key_high;
        logic [KEY_W-1:0]   out_key_low;
        logic [KIND_W-1:0]  out_kind;
        logic [COUNT_W-1:0] entry_count;
        logic [CTR_W-1:0]   generation_now;
        logic [CTR_W-1:0]   pairing_total;
    } t_out_item;

    // Stored entry contents
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [KEY_W-1:0]  key_high;
        logic [KEY_W-1:0]  key_low;
        logic [KIND_W-1:0] kind;
    } t_entry;

    // Priority chain passed from cell to cell (slot 0 first)
    typedef struct packed {
        logic hit;    // an earlier cell matched the address
        logic free;   // an earlier cell is empty
        logic iter;   // an earlier cell is a valid iteration candidate
    } t_chain;

    // Table-wide summary fed back to every cell
    typedef struct packed {
        logic any_hit;
        logic any_free;
    } t_glob;

    // Command broadcast to the cells
    typedef struct packed {
        logic     exec;
        t_in_item item;
    } t_cmd;

endpackage

@@ src/lkt_cell.sv @@
`timescale 1ns / 1ps
// lkt_cell: one slot of the link key table, holding a single entry.
// Passes match/free/iteration priority to its neighbor; depends on lkt_pkg.
module lkt_cell
    import lkt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  t_chain i_chain,
    input  t_glob  i_glob,
    input  logic   i_victim,     // this slot is the round-robin victim
    input  logic   i_iter_ok,    // this slot is at or past the iteration position
    output t_chain o_chain,
    output logic   o_deliver,    // this slot is delivered by iterate next
    output logic   o_valid_next,
    output t_entry o_rd          // entry data for the result, zero if not selected
);

    logic   r_valid;
    t_entry r_ent;
    logic   n_valid;

    logic match;
    logic hit_here;
    logic free_here;
    logic elig;
    logic deliver;
    logic wr;
    logic clr;
    t_op  op;

    assign op = t_op'(i_cmd.item.op);

    // Local compare and priority
    assign match     = r_valid && (r_ent.address == i_cmd.item.address);
    assign hit_here  = match && !i_chain.hit;
    assign free_here = !r_valid && !i_chain.free;
    assign elig      = r_valid && i_iter_ok;
    assign deliver   = elig && !i_chain.iter;

    assign o_chain.hit  = i_chain.hit  || match;
    assign o_chain.free = i_chain.free || !r_valid;
    assign o_chain.iter = i_chain.iter || elig;

    assign o_deliver = deliver && (op == OP_ITER);

    // Write select: store goes to match, else first free, else victim; restore only to first free on a miss
    always_comb begin
        wr  = 1'b0;
        clr = 1'b0;
        case (op)
            OP_STORE: begin
                wr = hit_here
                    || (!i_glob.any_hit && free_here)
                    || (!i_glob.any_hit && !i_glob.any_free && i_victim);
            end
            OP_RESTORE: begin
                wr = !i_glob.any_hit && free_here;
            end
            OP_DELETE: begin
                clr = hit_here;
            end
            OP_CLEAR: begin
                clr = 1'b1;
            end
            default: begin
                wr  = 1'b0;
                clr = 1'b0;
            end
        endcase
        wr  = wr && i_cmd.exec;
        clr = clr && i_cmd.exec;
    end

    always_comb begin
        n_valid = r_valid;
        if (wr) begin
            n_valid = 1'b1;
        end else if (clr) begin
            n_valid = 1'b0;
        end
    end

    assign o_valid_next = n_valid;

    // Read data: lookup returns key only, iterate returns the whole entry
    always_comb begin
        o_rd = '0;
        if (op == OP_LOOKUP && hit_here) begin
            o_rd          = r_ent;
            o_rd.address  = '0;
        end else if (op == OP_ITER && deliver) begin
            o_rd = r_ent;
        end
    end

    // Slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_ent.address  <= i_cmd.item.address;
            r_ent.key_high <= i_cmd.item.key_high;
            r_ent.key_low  <= i_cmd.item.key_low;
            r_ent.kind     <= i_cmd.item.key_kind;
        end
    end

endmodule

@@ src/link_key_table.sv @@
`timescale 1ns / 1ps
// link_key_table: top level of the fully associative link key table.
// Instantiates one lkt_cell per slot; depends on lkt_pkg.

// Each operation is captured in the capture register; then every slot cell
// compares the address while priority ripples down the row of cells to pick
// the hit, the first free slot or the round-robin victim, and the result is
// written to the output register. One item is in work at a time: a new item
// is taken only after the last one has been written to the output register,
// and a result left waiting there holds the next item in its capture stage
// until taken. All slots are empty after reset, with no clearing pass.
module link_key_table
    import lkt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    // Capture stage and control
    logic              r_busy;
    t_in_item          r_item;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [SLOT_W-1:0] r_victim;
    logic [CNT_W-1:0]  r_iter_pos;
    logic [CTR_W-1:0]  r_gen;
    logic [CTR_W-1:0]  r_pair;

    logic [SLOT_W-1:0] n_victim;
    logic [CNT_W-1:0]  n_iter_pos;
    logic [CTR_W-1:0]  n_gen;
    logic [CTR_W-1:0]  n_pair;
    t_out_item         n_out;

    logic   accept;
    logic   exec;
    t_cmd   cmd;
    t_glob  glob;
    t_op    op;
    t_entry rd;
    logic   any_deliver;
    logic [CNT_W-1:0] cnt;

    t_chain           chain   [SLOTS+1];
    t_entry           cell_rd [SLOTS];
    logic [SLOTS-1:0] deliver;
    logic [SLOTS-1:0] valid_next;
    logic [SLOTS-1:0] victim_hot;
    logic [SLOTS-1:0] iter_ok;

    assign accept     = i_in_valid && !r_busy;
    assign exec       = r_busy && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_busy;

    assign cmd.exec = exec;
    assign cmd.item = r_item;
    assign op       = t_op'(r_item.op);

    assign chain[0]      = '0;
    assign glob.any_hit  = chain[SLOTS].hit;
    assign glob.any_free = chain[SLOTS].free;

    // Row of slot cells
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        assign victim_hot[k] = (r_victim == SLOT_W'(k));
        assign iter_ok[k]    = (r_iter_pos <= CNT_W'(k));

        lkt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_chain      (chain[k]),
            .i_glob       (glob),
            .i_victim     (victim_hot[k]),
            .i_iter_ok    (iter_ok[k]),
            .o_chain      (chain[k+1]),
            .o_deliver    (deliver[k]),
            .o_valid_next (valid_next[k]),
            .o_rd         (cell_rd[k])
        );
    end

    // Merge read data and count entries; at most one cell drives nonzero data
    always_comb begin
        rd  = '0;
        cnt = '0;
        for (int k = 0; k < SLOTS; k++) begin
            rd  = rd | cell_rd[k];
            cnt = cnt + CNT_W'(valid_next[k]);
        end
    end

    assign any_deliver = |deliver;

    // Counters and pointers
    always_comb begin
        n_victim   = r_victim;
        n_iter_pos = r_iter_pos;
        n_gen      = r_gen;
        n_pair     = r_pair;
        case (op)
            OP_STORE: begin
                n_gen  = r_gen + 1'b1;
                n_pair = r_pair + 1'b1;
                if (!glob.any_hit && !glob.any_free) begin
                    n_victim = (r_victim == SLOT_W'(SLOTS - 1)) ? '0 : r_victim + 1'b1;
                end
            end
            OP_DELETE: begin
                if (glob.any_hit) begin
                    n_gen = r_gen + 1'b1;
                end
            end
            OP_ITER: begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (deliver[k]) begin
                        n_iter_pos = CNT_W'(k + 1);
                    end
                end
            end
            OP_RESTART: begin
                n_iter_pos = '0;
            end
            OP_CLEAR: begin
                n_victim = '0;
                n_gen    = r_gen + 1'b1;
            end
            OP_RESTORE: begin
                if (!glob.any_hit && glob.any_free) begin
                    n_gen = r_gen + 1'b1;
                end
            end
            default: begin
                n_victim = r_victim;
            end
        endcase
    end

    // Result item
    always_comb begin
        n_out.found = 1'b0;
        case (op)
            OP_LOOKUP, OP_STORE, OP_DELETE: n_out.found = glob.any_hit;
            OP_ITER:                        n_out.found = any_deliver;
            OP_RESTORE:                     n_out.found = !glob.any_hit && glob.any_free;
            default:                        n_out.found = 1'b0;
        endcase
        n_out.out_address    = rd.address;
        n_out.out_key_high   = rd.key_high;
        n_out.out_key_low    = rd.key_low;
        n_out.out_kind       = rd.kind;
        n_out.entry_count    = COUNT_W'(cnt);
        n_out.generation_now = n_gen;
        n_out.pairing_total  = n_pair;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_victim    <= '0;
            r_iter_pos  <= '0;
            r_gen       <= '0;
            r_pair      <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (exec) begin
                r_busy <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
                r_victim    <= n_victim;
                r_iter_pos  <= n_iter_pos;
                r_gen       <= n_gen;
                r_pair      <= n_pair;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
        if (exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // An accepted item is marked busy in the next cycle, held until executed
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy)
        else $error("accepted item not captured");

    // A result waiting under stall is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !exec)
        else $error("stalled result overwritten");

    // Every executed store bumps the pairing counter by one
    a_pair_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && op == OP_STORE) |=> (r_pair == $past(r_pair) + 1'b1))
        else $error("pairing counter not advanced on store");

    // Victim pointer stays within the table
    a_victim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_victim <= SLOT_W'(SLOTS - 1))
        else $error("victim pointer out of range");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking testbench for link_key_table.
// Keeps its own model of the six-slot key table and compares every result item.
// Depends on lkt_pkg and link_key_table.
module tb_top;
    import lkt_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 4;
    localparam int POOL_SIZE    = 8;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 40;

    // op code not used by the block
    localparam logic [OP_W-1:0]   OP_SPARE = 3'd7;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
    localparam logic [KEY_W-1:0]  KEY_MAX  = '1;
    localparam logic [KIND_W-1:0] KIND_MAX = '1;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_directed_row;

    // clock, reset and DUT ports
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      i_out_stall = 1'b0;

    // idle percentages for the current phase
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // shadow copy of the key table
    logic        slot_valid [SLOTS];
    t_entry      slot_entry [SLOTS];
    int unsigned next_victim;
    int unsigned iter_slot;
    logic [CTR_W-1:0] change_gen;
    logic [CTR_W-1:0] store_count;

    // results still owed by the block, oldest first
    t_out_item pending_results[$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    int unsigned fail_count    = 0;
    int unsigned results_seen  = 0;
    int unsigned cycle_count   = 0;

    link_key_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Table model
    // ---------------------------------------------------------------
    function automatic int match_slot(input logic [ADDR_W-1:0] addr);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_entry[i].address == addr)
                return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < SLOTS; i++)
            if (!slot_valid[i])
                return i;
        return -1;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_entry[i] = '0;
        end
    endfunction

    // Applies one operation to the shadow table and returns its result item.
    function automatic t_out_item apply_key_op(input t_in_item it);
        t_out_item   res;
        t_entry      fresh;
        int          s;
        int unsigned live;

        res   = '0;
        fresh = '{address: it.address, key_high: it.key_high,
                  key_low: it.key_low, kind: it.key_kind};
        case (it.op)
            OP_LOOKUP: begin
                s = match_slot(it.address);
                if (s >= 0) begin
                    res.found        = 1'b1;
                    res.out_key_high = slot_entry[s].key_high;
                    res.out_key_low  = slot_entry[s].key_low;
                    res.out_kind     = slot_entry[s].kind;
                end
            end
            OP_STORE: begin
                s = match_slot(it.address);
                if (s >= 0) begin
                    res.found = 1'b1;
                end else begin
                    s = free_slot();
                    // full table: overwrite the round-robin victim
                    if (s < 0) begin
                        if (next_victim >= SLOTS)
                            next_victim = 0;
                        s = int'(next_victim);
                        next_victim = (next_victim + 1) % SLOTS;
                    end
                end
                slot_valid[s] = 1'b1;
                slot_entry[s] = fresh;
                change_gen++;
                store_count++;
            end
            OP_DELETE: begin
                s = match_slot(it.address);
                if (s >= 0) begin
                    slot_valid[s] = 1'b0;
                    slot_entry[s] = '0;
                    change_gen++;
                    res.found = 1'b1;
                end
            end
            OP_ITER: begin
                for (int i = iter_slot; i < SLOTS; i++) begin
                    if (slot_valid[i]) begin
                        res.found        = 1'b1;
                        res.out_address  = slot_entry[i].address;
                        res.out_key_high = slot_entry[i].key_high;
                        res.out_key_low  = slot_entry[i].key_low;
                        res.out_kind     = slot_entry[i].kind;
                        iter_slot = i + 1;
                        break;
                    end
                end
            end
            OP_RESTART: iter_slot = 0;
            OP_CLEAR: begin
                clear_table();
                next_victim = 0;
                change_gen++;
            end
            OP_RESTORE: begin
                // insert only when absent and a slot is free
                if (match_slot(it.address) < 0) begin
                    s = free_slot();
                    if (s >= 0) begin
                        slot_valid[s] = 1'b1;
                        slot_entry[s] = fresh;
                        change_gen++;
                        res.found = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        live = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i])
                live++;
        res.entry_count    = live[COUNT_W-1:0];
        res.generation_now = change_gen;
        res.pairing_total  = store_count;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_in_item mk_item(input logic [OP_W-1:0] op,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [KEY_W-1:0] kh,
                                         input logic [KEY_W-1:0] kl,
                                         input logic [KIND_W-1:0] kind);
        return '{op: op, address: addr, key_high: kh, key_low: kl, key_kind: kind};
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[ADDR_W-1:0];
    endfunction

    // Mostly addresses from a small pool so hits, fills and evictions happen.
    function automatic t_in_item random_key_op();
        int unsigned      pick;
        logic [OP_W-1:0]  op;
        logic [ADDR_W-1:0] addr;

        if ($urandom_range(0, 99) < 5)
            addr_pool[$urandom_range(0, POOL_SIZE - 1)] = rand_addr();
        if ($urandom_range(0, 99) < 85)
            addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            addr = rand_addr();

        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_STORE;
        else if (pick < 50) op = OP_LOOKUP;
        else if (pick < 62) op = OP_DELETE;
        else if (pick < 77) op = OP_ITER;
        else if (pick < 82) op = OP_RESTART;
        else if (pick < 85) op = OP_CLEAR;
        else if (pick < 97) op = OP_RESTORE;
        else                op = OP_SPARE;
        return mk_item(op, addr, rand_key(), rand_key(), KIND_W'($urandom));
    endfunction

    // Presents one item, waits for it to be taken, and records its result.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item predicted;

        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = apply_key_op(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                      results_seen, name, got, want));
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;

        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none pending",
                                      results_seen));
        end else begin
            want = pending_results.pop_front();
            compare_field("found",          got.found,          want.found);
            compare_field("out_address",    got.out_address,    want.out_address);
            compare_field("out_key_high",   got.out_key_high,   want.out_key_high);
            compare_field("out_key_low",    got.out_key_low,    want.out_key_low);
            compare_field("out_kind",       got.out_kind,       want.out_kind);
            compare_field("entry_count",    got.entry_count,    want.entry_count);
            compare_field("generation_now", got.generation_now, want.generation_now);
            compare_field("pairing_total",  got.pairing_total,  want.pairing_total);
        end
        results_seen++;
    endtask

    // Result side: take items and stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_result(o_out_item);
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("link_key_table test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        t_directed_row directed[$];
        int unsigned   send_pct [NUM_PHASES];
        int unsigned   recv_pct [NUM_PHASES];

        send_pct = '{0, 66, 0, 34};
        recv_pct = '{0, 0, 66, 34};

        clear_table();
        next_victim = 0;
        iter_slot   = 0;
        change_gen  = '0;
        store_count = '0;
        addr_pool[0] = '0;
        addr_pool[1] = ADDR_MAX;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = rand_addr();

        // empty table: misses report all zero
        directed.push_back('{mk_item(OP_LOOKUP, '0, '0, '0, '0), 1, '0});
        directed.push_back('{mk_item(OP_ITER, '0, '0, '0, '0), 1, '0});
        directed.push_back('{mk_item(OP_DELETE, ADDR_MAX, '0, '0, '0), 1, '0});
        // restore into empty table, then read it back
        directed.push_back('{mk_item(OP_RESTORE, ADDR_MAX, KEY_MAX, KEY_MAX, KIND_MAX), 1,
            t_out_item'{found: 1'b1, entry_count: 3'd1, generation_now: 32'd1,
                        default: '0}});
        directed.push_back('{mk_item(OP_LOOKUP, ADDR_MAX, '0, '0, '0), 1,
            t_out_item'{found: 1'b1, out_key_high: KEY_MAX, out_key_low: KEY_MAX,
                        out_kind: KIND_MAX, entry_count: 3'd1, generation_now: 32'd1,
                        default: '0}});
        // store new, then update existing
        directed.push_back('{mk_item(OP_STORE, '0, '0, '0, '0), 1,
            t_out_item'{entry_count: 3'd2, generation_now: 32'd2, pairing_total: 32'd1,
                        default: '0}});
        directed.push_back('{mk_item(OP_STORE, ADDR_MAX, {4{16'hAAAA}}, {4{16'h5555}},
            4'd8), 1, t_out_item'{found: 1'b1, entry_count: 3'd2, generation_now: 32'd3,
                                  pairing_total: 32'd2, default: '0}});
        // restore refused: address present
        directed.push_back('{mk_item(OP_RESTORE, ADDR_MAX, rand_key(), rand_key(), 4'd1),
                             0, '0});
        // fill the table
        for (int a = 1; a <= 4; a++)
            directed.push_back('{mk_item(OP_STORE, ADDR_W'(a), rand_key(), rand_key(),
                                         KIND_W'(a)), 0, '0});
        // restore refused: table full; stores evict round-robin victims
        directed.push_back('{mk_item(OP_RESTORE, 48'd5, rand_key(), rand_key(), 4'd2),
                             0, '0});
        directed.push_back('{mk_item(OP_STORE, 48'd6, rand_key(), rand_key(), 4'd6), 0, '0});
        directed.push_back('{mk_item(OP_STORE, 48'd7, rand_key(), rand_key(), 4'd7), 0, '0});
        // iteration, rewind, spare op
        directed.push_back('{mk_item(OP_ITER, '0, '0, '0, '0), 0, '0});
        directed.push_back('{mk_item(OP_ITER, '0, '0, '0, '0), 0, '0});
        directed.push_back('{mk_item(OP_RESTART, '0, '0, '0, '0), 0, '0});
        directed.push_back('{mk_item(OP_ITER, '0, '0, '0, '0), 0, '0});
        directed.push_back('{mk_item(OP_SPARE, ADDR_MAX, KEY_MAX, KEY_MAX, KIND_MAX), 0, '0});
        // delete frees a slot, restore then succeeds
        directed.push_back('{mk_item(OP_DELETE, 48'd6, '0, '0, '0), 0, '0});
        directed.push_back('{mk_item(OP_RESTORE, 48'd5, rand_key(), rand_key(), 4'd5), 0, '0});
        // clear keeps the iteration position
        directed.push_back('{mk_item(OP_CLEAR, '0, '0, '0, '0), 0, '0});
        directed.push_back('{mk_item(OP_ITER, '0, '0, '0, '0), 0, '0});
        directed.push_back('{mk_item(OP_LOOKUP, 48'd1, '0, '0, '0), 0, '0});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed, directed[i].want);

        // random part across idling phases
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_key_op(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("link_key_table test passed");
        else
            $display("link_key_table test failed");
        $finish;
    end

endmodule
